@@ hdl/htid_pkg.sv @@
// Shared types and codes of the handle table ID allocator.
`timescale 1ns / 1ps
`default_nettype none
package htid_pkg;

    localparam int ID_W      = 8;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int OUT_VAL_W = 32;
    localparam int ID_FIELD_LIMIT = 256;

    localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_STACK_FULL = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch the input item, start memory reads
        logic fire;     // commit state updates and load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free; // output register empty or being taken this cycle
    } t_sts;

endpackage
`default_nettype wire

@@ hdl/htid_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module htid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ hdl/htid_ctrl.sv @@
// Controller state machine: sequences accept and execute of one item.
`timescale 1ns / 1ps
`default_nettype none
module htid_ctrl import htid_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold here until the output register can take the result
                o_cmd.fire = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/htid_datapath.sv @@
// Datapath: free stack, entry store, valid marks, counters, output register.
`timescale 1ns / 1ps
`default_nettype none
module htid_datapath import htid_pkg::*; #(
    parameter int ID_LIMIT         = 256,
    parameter int FREE_STACK_DEPTH = 256,
    parameter int VALUE_BITS       = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    input  wire logic [KIND_W-1:0]    i_kind,
    input  wire logic [ID_W-1:0]      i_handle_id,
    input  wire logic [OUT_VAL_W-1:0] i_entry_value,
    input  wire logic                 i_stall,
    output logic                      o_valid,
    output logic [ID_W-1:0]           o_new_id,
    output logic [OUT_VAL_W-1:0]      o_found_value,
    output logic [STATUS_W-1:0]       o_status
);

    localparam int EAW = $clog2(ID_LIMIT);
    localparam int SAW = $clog2(FREE_STACK_DEPTH);
    localparam int CW  = $clog2(FREE_STACK_DEPTH + 1);
    localparam logic [ID_W:0]   LIMIT_ID  = (ID_W + 1)'(ID_LIMIT);
    localparam logic [CW-1:0]   STACK_MAX = CW'(FREE_STACK_DEPTH);

    // latched item
    logic [KIND_W-1:0]     r_kind;
    logic [ID_W-1:0]       r_id;
    logic [VALUE_BITS-1:0] r_value;

    // allocator state
    logic [ID_W:0]         r_next_fresh;
    logic [CW-1:0]         r_free_count;
    logic [ID_LIMIT-1:0]   r_valid;

    // output register
    logic                  r_out_valid;
    logic [ID_W-1:0]       r_new_id;
    logic [OUT_VAL_W-1:0]  r_found;
    logic [STATUS_W-1:0]   r_status;

    logic [VALUE_BITS-1:0] in_value;
    logic [VALUE_BITS-1:0] store_rdata;
    logic [OUT_VAL_W-1:0]  store_rdata_out;
    logic [ID_W-1:0]       stack_rdata;
    logic [CW-1:0]         count_m1;

    logic                  store_we;
    logic [EAW-1:0]        store_waddr;
    logic [EAW-1:0]        store_raddr;
    logic                  stack_we;

    logic [ID_W:0]         n_next_fresh;
    logic [CW-1:0]         n_free_count;
    logic                  valid_set;
    logic                  valid_clr;
    logic [ID_W-1:0]       n_new_id;
    logic [OUT_VAL_W-1:0]  n_found;
    logic [STATUS_W-1:0]   n_status;

    logic                  id_ok;
    logic                  id_valid;
    logic [ID_W-1:0]       got;
    logic                  have;

    generate
        if (VALUE_BITS <= OUT_VAL_W) begin : g_narrow
            assign in_value        = i_entry_value[VALUE_BITS-1:0];
            assign store_rdata_out = OUT_VAL_W'(store_rdata);
        end else begin : g_wide
            assign in_value        = {{(VALUE_BITS-OUT_VAL_W){1'b0}}, i_entry_value};
            assign store_rdata_out = store_rdata[OUT_VAL_W-1:0];
        end
    endgenerate

    assign o_sts.out_free = !r_out_valid || !i_stall;
    assign count_m1       = r_free_count - 1'b1;
    // the store read address follows the input while an item is accepted, the latched item otherwise
    assign store_raddr    = i_cmd.accept ? i_handle_id[EAW-1:0] : r_id[EAW-1:0];

    htid_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ID_LIMIT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (r_value),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    htid_ram #(
        .WIDTH (ID_W),
        .DEPTH (FREE_STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (r_free_count[SAW-1:0]),
        .i_wdata (r_id),
        .i_raddr (count_m1[SAW-1:0]),
        .o_rdata (stack_rdata)
    );

    always_comb begin
        id_ok        = (r_id != '0) && ({1'b0, r_id} < LIMIT_ID);
        id_valid     = id_ok && r_valid[r_id[EAW-1:0]];
        got          = '0;
        have         = 1'b0;
        n_next_fresh = r_next_fresh;
        n_free_count = r_free_count;
        store_we     = 1'b0;
        store_waddr  = '0;
        stack_we     = 1'b0;
        valid_set    = 1'b0;
        valid_clr    = 1'b0;
        n_new_id     = '0;
        n_found      = '0;
        n_status     = STAT_OK;
        case (r_kind)
            KIND_CREATE: begin
                if (r_free_count != '0) begin
                    got          = stack_rdata;
                    have         = 1'b1;
                    n_free_count = count_m1;
                end else if (r_next_fresh < LIMIT_ID) begin
                    got          = r_next_fresh[ID_W-1:0];
                    have         = 1'b1;
                    n_next_fresh = r_next_fresh + 1'b1;
                end
                if (have && got != '0 && ({1'b0, got} < LIMIT_ID)) begin
                    store_we    = i_cmd.fire;
                    store_waddr = got[EAW-1:0];
                    valid_set   = 1'b1;
                    n_new_id    = got;
                end else begin
                    n_status = STAT_EXHAUSTED;
                end
            end
            KIND_REMOVE: begin
                if (id_valid) begin
                    valid_clr = 1'b1;
                end else begin
                    n_status = STAT_NOT_FOUND;
                end
            end
            KIND_FIND: begin
                if (id_valid) begin
                    n_found = store_rdata_out;
                end else begin
                    n_status = STAT_NOT_FOUND;
                end
            end
            KIND_RELEASE: begin
                if (!id_ok) begin
                    n_status = STAT_NOT_FOUND;
                end else if (r_free_count >= STACK_MAX) begin
                    n_status = STAT_STACK_FULL;
                end else begin
                    stack_we     = i_cmd.fire;
                    n_free_count = r_free_count + 1'b1;
                end
            end
            default: begin
                n_status = STAT_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_kind;
            r_id    <= i_handle_id;
            r_value <= in_value;
        end
        if (i_cmd.fire) begin
            r_new_id <= n_new_id;
            r_found  <= n_found;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_fresh <= (ID_W + 1)'(1);
            r_free_count <= '0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.fire) begin
                r_next_fresh <= n_next_fresh;
                r_free_count <= n_free_count;
                if (valid_set) begin
                    r_valid[got[EAW-1:0]] <= 1'b1;
                end
                if (valid_clr) begin
                    r_valid[r_id[EAW-1:0]] <= 1'b0;
                end
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_new_id      = r_new_id;
    assign o_found_value = r_found;
    assign o_status      = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= STACK_MAX)
        else $error("free count above stack depth");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_fresh != '0) && (r_next_fresh <= LIMIT_ID))
        else $error("fresh ID counter out of range");

    a_fire_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fire |-> (!r_out_valid || !i_stall))
        else $error("result committed over an untaken result");

    a_create_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fire && r_kind == KIND_CREATE) |=> ((r_status == STAT_OK) == (r_new_id != '0)))
        else $error("create status disagrees with new ID");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.fire |=> $stable(r_free_count) && $stable(r_next_fresh))
        else $error("allocator state changed without a committed item");

endmodule
`default_nettype wire

@@ hdl/handle_table_id_allocator_top.sv @@
// Top level of the handle table ID allocator.
// Usage:
//   Input channel (i_valid / o_stall) carries one request item: i_kind
//   (create, remove, find, release), i_handle_id and i_entry_value.
//   Output channel (o_valid / i_stall) returns one result item per request:
//   o_new_id, o_found_value and o_status.
//   An item is taken with the free-stack top and the entry store read at
//   once; the execute state that follows runs it and loads the output
//   register as soon as that is free, raising o_valid. No new item is
//   taken until the last one has committed: memory reads, then update.
//   o_stall is low only while the block waits for an item.
//   A finished result waits in the output register while the next item is
//   taken and read; if the receiver still stalls when that item is ready to
//   commit, it holds in execute and o_stall stays high.
//   Reset (i_rst_n low, synchronous) empties the free stack, sets the fresh
//   ID counter to 1 and clears all valid marks in the same cycle; there is
//   no clearing pass. Entry store and stack contents are left as they are.
//   Usable IDs run from 1 to min(ID_SPACE, 256) - 1; ID 0 is null.
`timescale 1ns / 1ps
`default_nettype none
module handle_table_id_allocator_top import htid_pkg::*; #(
    parameter int ID_SPACE         = 256,
    parameter int FREE_STACK_DEPTH = 256,
    parameter int VALUE_BITS       = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [KIND_W-1:0]    i_kind,
    input  wire logic [ID_W-1:0]      i_handle_id,
    input  wire logic [OUT_VAL_W-1:0] i_entry_value,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [ID_W-1:0]           o_new_id,
    output logic [OUT_VAL_W-1:0]      o_found_value,
    output logic [STATUS_W-1:0]       o_status
);

    localparam int ID_LIMIT = (ID_SPACE < ID_FIELD_LIMIT) ? ID_SPACE : ID_FIELD_LIMIT;

    t_cmd cmd;
    t_sts sts;

    htid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    htid_datapath #(
        .ID_LIMIT         (ID_LIMIT),
        .FREE_STACK_DEPTH (FREE_STACK_DEPTH),
        .VALUE_BITS       (VALUE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (i_kind),
        .i_handle_id   (i_handle_id),
        .i_entry_value (i_entry_value),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_new_id      (o_new_id),
        .o_found_value (o_found_value),
        .o_status      (o_status)
    );

endmodule
`default_nettype wire

@@ bench/handle_table_id_allocator_top_test.sv @@
// Self-checking bench for the handle table ID allocator: DUT results checked against a predictor.
`timescale 1ns / 1ps
module handle_table_id_allocator_top_test;
    import htid_pkg::*;

    localparam int ID_SPACE         = 256;
    localparam int FREE_STACK_DEPTH = 256;
    localparam int VALUE_BITS       = 32;
    localparam int ID_LIMIT = (ID_SPACE < ID_FIELD_LIMIT) ? ID_SPACE : ID_FIELD_LIMIT;
    localparam logic [OUT_VAL_W-1:0] VALUE_MASK = (VALUE_BITS >= OUT_VAL_W) ?
        {OUT_VAL_W{1'b1}} : {OUT_VAL_W{1'b1}} >> (OUT_VAL_W - VALUE_BITS);
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 24;

    typedef struct packed {
        logic [ID_W-1:0]      new_id;
        logic [OUT_VAL_W-1:0] found_value;
        logic [STATUS_W-1:0]  status;
    } t_reply;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_pattern;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [KIND_W-1:0]    i_kind;
    logic [ID_W-1:0]      i_handle_id;
    logic [OUT_VAL_W-1:0] i_entry_value;
    logic                 o_valid;
    logic                 i_stall;
    logic [ID_W-1:0]      o_new_id;
    logic [OUT_VAL_W-1:0] o_found_value;
    logic [STATUS_W-1:0]  o_status;

    // predicted table state
    logic [8:0]           fresh_id;
    logic [8:0]           free_depth;
    logic [ID_W-1:0]      free_ids [FREE_STACK_DEPTH];
    logic [OUT_VAL_W-1:0] stored_values [ID_SPACE];
    logic                 live_ids [ID_SPACE];

    t_reply pending_replies [$];
    int     errors      = 0;
    int     idle_cycles = 0;
    int     burst_left  = 0;
    int     holds_asked = 0;
    int     holds_done  = 0;

    handle_table_id_allocator_top #(
        .ID_SPACE(ID_SPACE),
        .FREE_STACK_DEPTH(FREE_STACK_DEPTH),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_kind(i_kind),
        .i_handle_id(i_handle_id),
        .i_entry_value(i_entry_value),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_new_id(o_new_id),
        .o_found_value(o_found_value),
        .o_status(o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic id_usable(input logic [ID_W-1:0] id);
        return id != '0 && int'(id) < ID_LIMIT;
    endfunction

    // Applies one request to the predicted table and returns its result.
    function automatic t_reply apply_request(input logic [KIND_W-1:0] kind,
                                             input logic [ID_W-1:0] id,
                                             input logic [OUT_VAL_W-1:0] value);
        t_reply          reply;
        logic [ID_W-1:0] got;
        logic            have;
        reply = '0;
        got = '0;
        have = 1'b0;
        reply.status = STAT_OK;
        case (kind)
            KIND_CREATE: begin
                // recycled IDs first, fresh counter only when the stack is empty
                if (free_depth != 0) begin
                    free_depth = free_depth - 1'b1;
                    got = free_ids[free_depth];
                    have = 1'b1;
                end else if (fresh_id < ID_LIMIT) begin
                    got = fresh_id[ID_W-1:0];
                    fresh_id = fresh_id + 1'b1;
                    have = 1'b1;
                end
                if (have && id_usable(got)) begin
                    stored_values[got] = value & VALUE_MASK;
                    live_ids[got] = 1'b1;
                    reply.new_id = got;
                end else begin
                    reply.status = STAT_EXHAUSTED;
                end
            end
            KIND_REMOVE: begin
                if (id_usable(id) && live_ids[id]) begin
                    live_ids[id] = 1'b0;
                end else begin
                    reply.status = STAT_NOT_FOUND;
                end
            end
            KIND_FIND: begin
                if (id_usable(id) && live_ids[id]) begin
                    reply.found_value = stored_values[id];
                end else begin
                    reply.status = STAT_NOT_FOUND;
                end
            end
            default: begin
                if (!id_usable(id)) begin
                    reply.status = STAT_NOT_FOUND;
                end else if (free_depth >= FREE_STACK_DEPTH) begin
                    reply.status = STAT_STACK_FULL;
                end else begin
                    free_ids[free_depth] = id;
                    free_depth = free_depth + 1'b1;
                end
            end
        endcase
        return reply;
    endfunction

    function automatic logic [ID_W-1:0] pick_live_id();
        logic [ID_W-1:0] id;
        id = ID_W'(1);
        for (int n = 0; n < 8; n++) begin
            id = ID_W'($urandom_range(1, ID_LIMIT - 1));
            if (live_ids[id]) return id;
        end
        return id;
    endfunction

    // Offers one item, entered and left at a falling edge.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                input logic [OUT_VAL_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_handle_id   <= id;
        i_entry_value <= value;
        do @(posedge i_clk); while (o_stall);
        pending_replies.push_back(apply_request(kind, id, value));
        @(negedge i_clk);
    endtask

    task automatic test_basic_ops();
        // null and never-issued IDs
        send_request(KIND_FIND, 8'd0, 32'hFFFF_FFFF);
        send_request(KIND_REMOVE, 8'd0, 32'd0);
        send_request(KIND_RELEASE, 8'd0, 32'd0);
        send_request(KIND_FIND, 8'd255, 32'd0);
        send_request(KIND_REMOVE, 8'd255, 32'd0);
        // fresh IDs with value extremes
        send_request(KIND_CREATE, 8'd255, 32'd0);
        send_request(KIND_CREATE, 8'd0, 32'hFFFF_FFFF);
        send_request(KIND_CREATE, 8'd0, 32'hA5A5_5A5A);
        send_request(KIND_FIND, 8'd1, 32'd0);
        send_request(KIND_FIND, 8'd2, 32'd0);
        send_request(KIND_FIND, 8'd3, 32'd0);
        // removed ID is gone and not recycled until released
        send_request(KIND_REMOVE, 8'd2, 32'd0);
        send_request(KIND_FIND, 8'd2, 32'd0);
        send_request(KIND_REMOVE, 8'd2, 32'd0);
        send_request(KIND_RELEASE, 8'd2, 32'd0);
        send_request(KIND_CREATE, 8'd0, 32'h1234_5678);
        send_request(KIND_FIND, 8'd2, 32'd0);
        // recycled ID that is still live gets overwritten
        send_request(KIND_RELEASE, 8'd3, 32'd0);
        send_request(KIND_CREATE, 8'd0, 32'hDEAD_BEEF);
        send_request(KIND_FIND, 8'd3, 32'd0);
        // duplicate and never-issued releases
        send_request(KIND_RELEASE, 8'd1, 32'd0);
        send_request(KIND_RELEASE, 8'd1, 32'd0);
        send_request(KIND_RELEASE, 8'd200, 32'd0);
        send_request(KIND_CREATE, 8'd0, 32'h0000_0001);
        send_request(KIND_CREATE, 8'd0, 32'h8000_0000);
        send_request(KIND_CREATE, 8'd0, 32'h7FFF_FFFF);
        send_request(KIND_FIND, 8'd200, 32'd0);
    endtask

    task automatic test_id_exhaustion();
        while (free_depth != 0 || fresh_id < ID_LIMIT) begin
            send_request(KIND_CREATE, ID_W'($urandom), $urandom);
            if ($urandom_range(0, 7) == 0) send_request(KIND_FIND, pick_live_id(), $urandom);
        end
        repeat (2) send_request(KIND_CREATE, ID_W'($urandom), $urandom);
    endtask

    task automatic test_random_traffic();
        int              roll;
        logic [ID_W-1:0] id;
        repeat (RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) id = ID_W'($urandom_range(0, 255));
            else id = pick_live_id();
            if (roll < 30) send_request(KIND_CREATE, ID_W'($urandom), $urandom);
            else if (roll < 60) send_request(KIND_FIND, id, $urandom);
            else if (roll < 80) send_request(KIND_REMOVE, id, $urandom);
            else send_request(KIND_RELEASE, ID_W'($urandom_range(0, ID_LIMIT - 1)), $urandom);
        end
    endtask

    task automatic test_stack_full();
        while (free_depth < FREE_STACK_DEPTH)
            send_request(KIND_RELEASE, ID_W'($urandom_range(1, ID_LIMIT - 1)), $urandom);
        send_request(KIND_RELEASE, ID_W'(ID_LIMIT - 1), $urandom);
        send_request(KIND_RELEASE, 8'd1, $urandom);
        // null check wins over the full check
        send_request(KIND_RELEASE, 8'd0, $urandom);
        repeat (4) begin
            send_request(KIND_CREATE, ID_W'($urandom), $urandom);
            send_request(KIND_FIND, pick_live_id(), $urandom);
        end
    endtask

    task automatic test_backpressure();
        holds_asked++;
        repeat (24) begin
            if ($urandom_range(0, 1)) send_request(KIND_CREATE, ID_W'($urandom), $urandom);
            else send_request(KIND_FIND, pick_live_id(), $urandom);
        end
    endtask

    // result receiver: random stall patterns plus long holds on request
    initial begin
        t_stall_pattern pattern;
        int             pattern_left;
        int             hold_left;
        int             phase;
        logic           stall_next;
        pattern = STALL_NONE;
        pattern_left = 0;
        hold_left = 0;
        phase = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (holds_done != holds_asked) begin
                holds_done++;
                hold_left = HOLD_CYCLES - 1;
                stall_next = 1'b1;
            end else begin
                if (pattern_left == 0) begin
                    pattern = t_stall_pattern'($urandom_range(0, 3));
                    pattern_left = $urandom_range(16, 96);
                end
                pattern_left--;
                case (pattern)
                    STALL_NONE:     stall_next = 1'b0;
                    STALL_COIN:     stall_next = 1'($urandom_range(0, 1));
                    STALL_PERIODIC: stall_next = (phase % 3 == 0);
                    default:        stall_next = ($urandom_range(0, 9) < 8);
                endcase
            end
            i_stall <= stall_next;
        end
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (o_valid && !i_stall) begin
                if (pending_replies.size() == 0) begin
                    $error("unexpected result item: new_id %0d found_value %h status %0d",
                           o_new_id, o_found_value, o_status);
                    errors++;
                end else begin
                    want = pending_replies.pop_front();
                    if (o_new_id !== want.new_id) begin
                        $error("new_id: expected %0d, actual %0d", want.new_id, o_new_id);
                        errors++;
                    end
                    if (o_found_value !== want.found_value) begin
                        $error("found_value: expected %h, actual %h",
                               want.found_value, o_found_value);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL handle_table_id_allocator_top");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_kind        = KIND_CREATE;
        i_handle_id   = '0;
        i_entry_value = '0;
        fresh_id      = 9'd1;
        free_depth    = '0;
        foreach (live_ids[i]) live_ids[i] = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_id_exhaustion();
        test_random_traffic();
        test_stack_full();
        test_backpressure();

        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS handle_table_id_allocator_top");
        end else begin
            $display("FAIL handle_table_id_allocator_top");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/htid_pkg.sv
hdl/htid_ram.sv
hdl/htid_ctrl.sv
hdl/htid_datapath.sv
hdl/handle_table_id_allocator_top.sv
bench/handle_table_id_allocator_top_test.sv
